>>> design/ssm_pkg.sv
// Shared types, constants and the reciprocal table for the sine-flow map step.
package ssm_pkg;

    // Fraction bits of positions, amplitude and domain length.
    localparam int POS_FRAC_BITS = 20;

    // Angles are held with 60 fraction bits.
    localparam logic [63:0] TWO_PI_Q60     = 64'h6487ED5110B4611A;
    localparam logic [63:0] PI_Q60         = TWO_PI_Q60 >> 1;
    localparam logic [63:0] HALF_PI_Q60    = TWO_PI_Q60 >> 2;
    localparam logic [63:0] QUARTER_PI_Q60 = TWO_PI_Q60 >> 3;

    // Unwrapped coordinates: signed, magnitude below 2^34.
    localparam int COORD_W = 35;
    localparam int MAG_W   = 34;

    // Wave number times coordinate magnitude.
    localparam int PROD_W = 65;

    // Angle reduction modulo 2*pi at 24+P fraction bits.
    localparam int          ANG_SH          = 36 - POS_FRAC_BITS;
    localparam int          ANG_M_W         = 63 - ANG_SH;
    localparam logic [63:0] ANG_M           = TWO_PI_Q60 >> ANG_SH;
    localparam int          ANG_INIT_W      = ANG_M_W - 1;
    localparam int          RED_STEPS       = PROD_W - ANG_INIT_W;
    localparam int          STEPS_PER_STAGE = 2;
    localparam int          RED_STAGES      = (RED_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // Remainder of the wrap: one quotient bit per coordinate magnitude bit.
    localparam int WRAP_STEPS  = MAG_W;
    localparam int WRAP_STAGES = (WRAP_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // Series evaluation.
    localparam int          COS_SLOTS = 7;
    localparam int          RECIP_W   = 38;
    localparam logic [30:0] ONE_Q30   = 31'h40000000;

    // Register reset values and indexes.
    localparam logic [31:0] LEN_RESET  = 32'd1 << POS_FRAC_BITS;
    localparam logic [31:0] WAVE_RESET = 32'h01000000;
    localparam int          REG_IDX_W  = 3;
    localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WAVE_NUMBER   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PHASE_X       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PHASE_Y       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DOMAIN_LENGTH = 3'd4;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
    } in_t;

    typedef struct packed {
        logic [31:0] new_x;
        logic [31:0] new_y;
    } out_t;

    // Pair of coordinates carried alongside the arithmetic.
    typedef struct packed {
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
    } coord_pair_t;

    // Reciprocals ceil(2^38 / den) of the series denominators; zero skips a slot.
    function automatic logic [RECIP_W-1:0] cos_recip(input logic [2:0] slot,
                                                      input logic sin_sel);
        logic [RECIP_W-1:0] r;
        r = '0;
        if (sin_sel)
        begin
            unique case (slot)
                3'd0: r = 38'd0;
                3'd1: r = 38'd1762037866;
                3'd2: r = 38'd2498890064;
                3'd3: r = 38'd3817748708;
                3'd4: r = 38'd6544712071;
                3'd5: r = 38'd13743895348;
                3'd6: r = 38'd45812984491;
                default: r = 38'd0;
            endcase
        end
        else
        begin
            unique case (slot)
                3'd0: r = 38'd1510318171;
                3'd1: r = 38'd2082408386;
                3'd2: r = 38'd3054198967;
                3'd3: r = 38'd4908534053;
                3'd4: r = 38'd9162596899;
                3'd5: r = 38'd22906492246;
                3'd6: r = 38'd137438953472;
                default: r = 38'd0;
            endcase
        end
        return r;
    endfunction

endpackage

>>> design/ssm_angle.sv
// Pipelined angle unit: (wave number * coordinate + phase) modulo 2*pi.
module ssm_angle (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [ssm_pkg::COORD_W-1:0] coord,
    input  ssm_pkg::coord_pair_t          in_side,
    input  logic [31:0]                   wave_number,
    input  logic [31:0]                   phase,
    output logic                          out_valid,
    output logic [62:0]                   angle,
    output ssm_pkg::coord_pair_t          out_side
);

    typedef struct packed {
        logic [ssm_pkg::ANG_M_W-1:0]   rem;
        logic [ssm_pkg::RED_STEPS-1:0] rest;
        logic                          neg;
        ssm_pkg::coord_pair_t          side;
    } red_t;

    localparam logic [ssm_pkg::ANG_M_W:0] M_WIDE = ssm_pkg::ANG_M[ssm_pkg::ANG_M_W:0];

    logic [31:0]                 km;
    logic [ssm_pkg::MAG_W-1:0]   vm;
    logic                        s1_valid_reg;
    logic [63:0]                 s1_lo_reg;
    logic [33:0]                 s1_hi_reg;
    logic                        s1_neg_reg;
    ssm_pkg::coord_pair_t        s1_side_reg;
    logic                        s2_valid_reg;
    logic [ssm_pkg::PROD_W-1:0]  s2_prod_reg;
    logic                        s2_neg_reg;
    ssm_pkg::coord_pair_t        s2_side_reg;
    logic [65:0]                 prod_sum;
    logic [ssm_pkg::RED_STAGES:0] red_vld_reg;
    red_t                        red_reg [0:ssm_pkg::RED_STAGES];
    red_t                        red_next [0:ssm_pkg::RED_STAGES-1];
    logic [ssm_pkg::ANG_M_W:0]   wide;
    logic                        fold_valid_reg;
    logic [ssm_pkg::ANG_M_W-1:0] fold_reg;
    ssm_pkg::coord_pair_t        fold_side_reg;
    logic [63:0]                 phase_wide;
    logic [63:0]                 pr1_reg;
    logic                        pneg_reg;
    logic [63:0]                 pr2_reg;
    logic [63:0]                 sum;
    logic                        out_valid_reg;
    logic [62:0]                 angle_reg;
    ssm_pkg::coord_pair_t        out_side_reg;

    // Magnitudes of the operands.
    assign km = wave_number[31] ? (~wave_number + 32'd1) : wave_number;
    assign vm = coord[ssm_pkg::COORD_W-1] ? ssm_pkg::MAG_W'(-coord)
                                          : coord[ssm_pkg::MAG_W-1:0];

    // The product is split into two partial products and summed a stage later.
    assign prod_sum = {2'b00, s1_lo_reg} + {s1_hi_reg, 32'd0};

    // Phase residue, taken straight from the register and refreshed every cycle.
    assign phase_wide = {(phase[31] ? (~phase + 32'd1) : phase), 32'd0};

    // Restoring remainder steps, two per stage.
    always_comb
    begin
        wide = '0;
        for (int j = 0; j < ssm_pkg::RED_STAGES; j++)
        begin
            red_next[j] = red_reg[j];
            for (int k = 0; k < ssm_pkg::STEPS_PER_STAGE; k++)
            begin
                if (j * ssm_pkg::STEPS_PER_STAGE + k < ssm_pkg::RED_STEPS)
                begin
                    wide = {red_next[j].rem, red_next[j].rest[ssm_pkg::RED_STEPS-1]};
                    if (wide >= M_WIDE)
                    begin
                        wide = wide - M_WIDE;
                    end
                    red_next[j].rem  = wide[ssm_pkg::ANG_M_W-1:0];
                    red_next[j].rest = red_next[j].rest << 1;
                end
            end
        end
    end

    // Residue of the product placed at 60 fraction bits plus the phase, reduced once.
    always_comb
    begin
        sum = {fold_reg, {ssm_pkg::ANG_SH{1'b0}}} + pr2_reg;
        if (sum >= ssm_pkg::TWO_PI_Q60)
        begin
            sum = sum - ssm_pkg::TWO_PI_Q60;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            red_vld_reg    <= '0;
            fold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= in_valid;
            s2_valid_reg   <= s1_valid_reg;
            red_vld_reg    <= {red_vld_reg[ssm_pkg::RED_STAGES-1:0], s2_valid_reg};
            fold_valid_reg <= red_vld_reg[ssm_pkg::RED_STAGES];
            out_valid_reg  <= fold_valid_reg;
        end
    end

    // Data path.
    always_ff @(posedge clk)
    begin
        s1_lo_reg   <= 64'(km) * 64'(vm[31:0]);
        s1_hi_reg   <= 34'(km) * 34'(vm[ssm_pkg::MAG_W-1:32]);
        s1_neg_reg  <= wave_number[31] ^ coord[ssm_pkg::COORD_W-1];
        s1_side_reg <= in_side;

        s2_prod_reg <= prod_sum[ssm_pkg::PROD_W-1:0];
        s2_neg_reg  <= s1_neg_reg;
        s2_side_reg <= s1_side_reg;

        red_reg[0].rem  <= {1'b0, s2_prod_reg[ssm_pkg::PROD_W-1 -: ssm_pkg::ANG_INIT_W]};
        red_reg[0].rest <= s2_prod_reg[ssm_pkg::RED_STEPS-1:0];
        red_reg[0].neg  <= s2_neg_reg;
        red_reg[0].side <= s2_side_reg;
        for (int j = 0; j < ssm_pkg::RED_STAGES; j++)
        begin
            red_reg[j+1] <= red_next[j];
        end

        // A negative product folds its residue back into [0, 2*pi).
        if (red_reg[ssm_pkg::RED_STAGES].neg && (red_reg[ssm_pkg::RED_STAGES].rem != '0))
        begin
            fold_reg <= ssm_pkg::ANG_M[ssm_pkg::ANG_M_W-1:0]
                        - red_reg[ssm_pkg::RED_STAGES].rem;
        end
        else
        begin
            fold_reg <= red_reg[ssm_pkg::RED_STAGES].rem;
        end
        fold_side_reg <= red_reg[ssm_pkg::RED_STAGES].side;

        pr1_reg  <= (phase_wide >= ssm_pkg::TWO_PI_Q60) ? phase_wide - ssm_pkg::TWO_PI_Q60
                                                        : phase_wide;
        pneg_reg <= phase[31];
        pr2_reg  <= (pneg_reg && (pr1_reg != 64'd0)) ? ssm_pkg::TWO_PI_Q60 - pr1_reg
                                                     : pr1_reg;

        angle_reg    <= sum[62:0];
        out_side_reg <= fold_side_reg;
    end

    assign out_valid = out_valid_reg;
    assign angle     = angle_reg;
    assign out_side  = out_side_reg;

endmodule

>>> design/ssm_cos.sv
// Pipelined cosine: symmetry folding and a nested Taylor series in Q30.
module ssm_cos (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [62:0]          angle,
    input  ssm_pkg::coord_pair_t in_side,
    output logic                 out_valid,
    output logic [30:0]          cos_mag,
    output logic                 cos_neg,
    output ssm_pkg::coord_pair_t out_side
);

    localparam int SER_STAGES = 2 * ssm_pkg::COS_SLOTS;

    typedef struct packed {
        logic [29:0]          b;
        logic [29:0]          s;
        logic [30:0]          t;
        logic [29:0]          x;
        logic                 sin_sel;
        logic                 neg;
        ssm_pkg::coord_pair_t side;
    } ser_t;

    logic                 c1_valid_reg;
    logic [62:0]          c1_a_reg;
    ssm_pkg::coord_pair_t c1_side_reg;
    logic                 c2_valid_reg;
    logic [62:0]          c2_a_reg;
    logic                 c2_neg_reg;
    ssm_pkg::coord_pair_t c2_side_reg;
    logic                 c3_valid_reg;
    logic [29:0]          c3_b_reg;
    logic                 c3_sin_reg;
    logic                 c3_neg_reg;
    ssm_pkg::coord_pair_t c3_side_reg;
    logic [63:0]          c3_arg;
    logic [59:0]          bb;
    logic [SER_STAGES:0]  ser_vld_reg;
    ser_t                 ser_reg [0:SER_STAGES];
    ser_t                 ser_next [0:SER_STAGES-1];
    logic [60:0]          st_prod;
    logic [67:0]          xr_prod;
    logic [60:0]          bt_prod;
    logic                 out_valid_reg;
    logic [30:0]          cos_mag_reg;
    logic                 cos_neg_reg;
    ssm_pkg::coord_pair_t out_side_reg;

    // Argument reduced to [0, pi/4]; above pi/4 the sine series of the complement is used.
    always_comb
    begin
        if ({1'b0, c2_a_reg} > ssm_pkg::QUARTER_PI_Q60)
        begin
            c3_arg = ssm_pkg::HALF_PI_Q60 - {1'b0, c2_a_reg};
        end
        else
        begin
            c3_arg = {1'b0, c2_a_reg};
        end
    end

    assign bb = 60'(c3_b_reg) * 60'(c3_b_reg);

    // Series slots: an even stage forms s*t, an odd stage divides by the denominator.
    always_comb
    begin
        st_prod = '0;
        xr_prod = '0;
        for (int i = 0; i < SER_STAGES; i++)
        begin
            ser_next[i] = ser_reg[i];
            if ((i % 2) == 0)
            begin
                st_prod       = 61'(ser_reg[i].s) * 61'(ser_reg[i].t);
                ser_next[i].x = st_prod[59:30];
            end
            else
            begin
                xr_prod = 68'(ser_reg[i].x)
                          * 68'(ssm_pkg::cos_recip(3'(i / 2), ser_reg[i].sin_sel));
                ser_next[i].t = ssm_pkg::ONE_Q30 - 31'(xr_prod[67:38]);
            end
        end
    end

    assign bt_prod = 61'(ser_reg[SER_STAGES].b) * 61'(ser_reg[SER_STAGES].t);

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg  <= 1'b0;
            c2_valid_reg  <= 1'b0;
            c3_valid_reg  <= 1'b0;
            ser_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            c1_valid_reg  <= in_valid;
            c2_valid_reg  <= c1_valid_reg;
            c3_valid_reg  <= c2_valid_reg;
            ser_vld_reg   <= {ser_vld_reg[SER_STAGES-1:0], c3_valid_reg};
            out_valid_reg <= ser_vld_reg[SER_STAGES];
        end
    end

    // Data path.
    always_ff @(posedge clk)
    begin
        // Fold (pi, 2*pi) onto (0, pi).
        c1_a_reg    <= ({1'b0, angle} > ssm_pkg::PI_Q60)
                       ? 63'(ssm_pkg::TWO_PI_Q60 - {1'b0, angle}) : angle;
        c1_side_reg <= in_side;

        // Fold (pi/2, pi) onto (0, pi/2) with a sign change.
        if ({1'b0, c1_a_reg} > ssm_pkg::HALF_PI_Q60)
        begin
            c2_a_reg   <= 63'(ssm_pkg::PI_Q60 - {1'b0, c1_a_reg});
            c2_neg_reg <= 1'b1;
        end
        else
        begin
            c2_a_reg   <= c1_a_reg;
            c2_neg_reg <= 1'b0;
        end
        c2_side_reg <= c1_side_reg;

        c3_b_reg    <= c3_arg[59:30];
        c3_sin_reg  <= ({1'b0, c2_a_reg} > ssm_pkg::QUARTER_PI_Q60);
        c3_neg_reg  <= c2_neg_reg;
        c3_side_reg <= c2_side_reg;

        ser_reg[0].b       <= c3_b_reg;
        ser_reg[0].s       <= bb[59:30];
        ser_reg[0].t       <= ssm_pkg::ONE_Q30;
        ser_reg[0].x       <= '0;
        ser_reg[0].sin_sel <= c3_sin_reg;
        ser_reg[0].neg     <= c3_neg_reg;
        ser_reg[0].side    <= c3_side_reg;
        for (int i = 0; i < SER_STAGES; i++)
        begin
            ser_reg[i+1] <= ser_next[i];
        end

        // The sine series is finished by a final multiply by its argument.
        cos_mag_reg  <= ser_reg[SER_STAGES].sin_sel ? bt_prod[60:30] : ser_reg[SER_STAGES].t;
        cos_neg_reg  <= ser_reg[SER_STAGES].neg;
        out_side_reg <= ser_reg[SER_STAGES].side;
    end

    assign out_valid = out_valid_reg;
    assign cos_mag   = cos_mag_reg;
    assign cos_neg   = cos_neg_reg;
    assign out_side  = out_side_reg;

endmodule

>>> design/ssm_wrap.sv
// Pipelined wrap of both coordinates into [0, domain length) by a true remainder.
module ssm_wrap (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  ssm_pkg::coord_pair_t coords,
    input  logic [31:0]          domain_length,
    output logic                 out_valid,
    output ssm_pkg::out_t        result
);

    typedef struct packed {
        logic [31:0]                 rem;
        logic [ssm_pkg::MAG_W-1:0]   rest;
        logic                        neg;
        logic [31:0]                 low;
    } lane_t;

    logic [ssm_pkg::WRAP_STAGES:0] vld_reg;
    lane_t                         lane_reg [0:ssm_pkg::WRAP_STAGES][0:1];
    lane_t                         lane_next [0:ssm_pkg::WRAP_STAGES-1][0:1];
    logic [32:0]                   wide;
    logic [31:0]                   fin [0:1];
    logic                          out_valid_reg;
    ssm_pkg::out_t                 result_reg;
    logic signed [ssm_pkg::COORD_W-1:0] lane_in [0:1];

    assign lane_in[0] = coords.a;
    assign lane_in[1] = coords.b;

    // Restoring division steps on the magnitude, two per stage and lane.
    always_comb
    begin
        wide = '0;
        for (int j = 0; j < ssm_pkg::WRAP_STAGES; j++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                lane_next[j][l] = lane_reg[j][l];
                for (int k = 0; k < ssm_pkg::STEPS_PER_STAGE; k++)
                begin
                    if (j * ssm_pkg::STEPS_PER_STAGE + k < ssm_pkg::WRAP_STEPS)
                    begin
                        wide = {lane_next[j][l].rem, lane_next[j][l].rest[ssm_pkg::MAG_W-1]};
                        if (wide >= {1'b0, domain_length})
                        begin
                            wide = wide - {1'b0, domain_length};
                        end
                        lane_next[j][l].rem  = wide[31:0];
                        lane_next[j][l].rest = lane_next[j][l].rest << 1;
                    end
                end
            end
        end
    end

    // Negative values fold the remainder; a zero length keeps the low 32 bits.
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (domain_length == 32'd0)
            begin
                fin[l] = lane_reg[ssm_pkg::WRAP_STAGES][l].low;
            end
            else if (lane_reg[ssm_pkg::WRAP_STAGES][l].neg
                     && (lane_reg[ssm_pkg::WRAP_STAGES][l].rem != 32'd0))
            begin
                fin[l] = domain_length - lane_reg[ssm_pkg::WRAP_STAGES][l].rem;
            end
            else
            begin
                fin[l] = lane_reg[ssm_pkg::WRAP_STAGES][l].rem;
            end
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= {vld_reg[ssm_pkg::WRAP_STAGES-1:0], in_valid};
            out_valid_reg <= vld_reg[ssm_pkg::WRAP_STAGES];
        end
    end

    // Data path.
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            lane_reg[0][l].rem  <= 32'd0;
            lane_reg[0][l].rest <= lane_in[l][ssm_pkg::COORD_W-1]
                                   ? ssm_pkg::MAG_W'(-lane_in[l])
                                   : lane_in[l][ssm_pkg::MAG_W-1:0];
            lane_reg[0][l].neg  <= lane_in[l][ssm_pkg::COORD_W-1];
            lane_reg[0][l].low  <= lane_in[l][31:0];
            for (int j = 0; j < ssm_pkg::WRAP_STAGES; j++)
            begin
                lane_reg[j+1][l] <= lane_next[j][l];
            end
        end
        result_reg.new_x <= fin[0];
        result_reg.new_y <= fin[1];
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

>>> design/sinusoidal_shear_map_step.sv
// Top level of the sine-flow map step: register file, the two map halves and the wrap.
//
// Each beat on start carries one particle position; busy is never raised, so a new
// position may be given in every clock cycle. The result comes out on result with done
// high for one cycle. At the default position format, each map half passes through a
// 15-stage angle unit (a multiply and a restoring modulo-2*pi chain of two bits per
// stage), a 19-stage cosine pipeline and two displacement stages; the final wrap is a
// 19-stage restoring remainder by the domain length. Results leave in the order the
// positions arrived, and the receiver must take each one in its cycle. The user writes
// registers over the APB port only while no position is in flight; nothing enforces it.
module sinusoidal_shear_map_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ssm_pkg::in_t        item,
    output logic                done,
    output ssm_pkg::out_t       result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [31:0]          amplitude_reg;
    logic [31:0]          wave_number_reg;
    logic [31:0]          phase_x_reg;
    logic [31:0]          phase_y_reg;
    logic [31:0]          domain_length_reg;
    logic [ssm_pkg::REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    logic [31:0]          amp_mag;

    ssm_pkg::coord_pair_t ax_side;
    logic                 ax_valid;
    logic [62:0]          ax_angle;
    ssm_pkg::coord_pair_t ax_side_out;
    logic                 cx_valid;
    logic [30:0]          cx_mag;
    logic                 cx_neg;
    ssm_pkg::coord_pair_t cx_side;

    logic                 d1_valid_reg;
    logic [31:0]          d1_d_reg;
    logic                 d1_neg_reg;
    ssm_pkg::coord_pair_t d1_side_reg;
    logic                 d2_valid_reg;
    logic signed [ssm_pkg::COORD_W-1:0] d2_xn_reg;
    ssm_pkg::coord_pair_t d2_side_reg;

    logic                 ay_valid;
    logic [62:0]          ay_angle;
    ssm_pkg::coord_pair_t ay_side;
    logic                 cy_valid;
    logic [30:0]          cy_mag;
    logic                 cy_neg;
    ssm_pkg::coord_pair_t cy_side;

    logic                 d3_valid_reg;
    logic [31:0]          d3_d_reg;
    logic                 d3_neg_reg;
    ssm_pkg::coord_pair_t d3_side_reg;
    logic                 d4_valid_reg;
    ssm_pkg::coord_pair_t d4_pair_reg;

    logic [7:0]           inflight_reg;
    logic [7:0]           inflight_next;

    // |amplitude| * |cos| in Q30, truncated.
    function automatic logic [31:0] disp_mag(input logic [31:0] amag, input logic [30:0] c);
        logic [62:0] p;
        p = 63'(amag) * 63'(c);
        return p[61:30];
    endfunction

    // Signed displacement added to an unwrapped coordinate.
    function automatic logic signed [ssm_pkg::COORD_W-1:0] add_disp(
        input logic signed [ssm_pkg::COORD_W-1:0] base,
        input logic [31:0] d,
        input logic neg);
        logic signed [ssm_pkg::COORD_W-1:0] ds;
        ds = $signed({3'b000, d});
        return neg ? base - ds : base + ds;
    endfunction

    // Register file.
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign busy    = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg     <= 32'd0;
            wave_number_reg   <= ssm_pkg::WAVE_RESET;
            phase_x_reg       <= 32'd0;
            phase_y_reg       <= 32'd0;
            domain_length_reg <= ssm_pkg::LEN_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                ssm_pkg::REG_AMPLITUDE:     amplitude_reg     <= pwdata;
                ssm_pkg::REG_WAVE_NUMBER:   wave_number_reg   <= pwdata;
                ssm_pkg::REG_PHASE_X:       phase_x_reg       <= pwdata;
                ssm_pkg::REG_PHASE_Y:       phase_y_reg       <= pwdata;
                ssm_pkg::REG_DOMAIN_LENGTH: domain_length_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ssm_pkg::REG_AMPLITUDE:     prdata = amplitude_reg;
            ssm_pkg::REG_WAVE_NUMBER:   prdata = wave_number_reg;
            ssm_pkg::REG_PHASE_X:       prdata = phase_x_reg;
            ssm_pkg::REG_PHASE_Y:       prdata = phase_y_reg;
            ssm_pkg::REG_DOMAIN_LENGTH: prdata = domain_length_reg;
            default:                    prdata = 32'd0;
        endcase
    end

    assign amp_mag = amplitude_reg[31] ? (~amplitude_reg + 32'd1) : amplitude_reg;

    // First half: x moves by the flow at y.
    assign ax_side.a = $signed({3'b000, item.pos_x});
    assign ax_side.b = $signed({3'b000, item.pos_y});

    ssm_angle u_angle_x (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start),
        .coord       ($signed({3'b000, item.pos_y})),
        .in_side     (ax_side),
        .wave_number (wave_number_reg),
        .phase       (phase_x_reg),
        .out_valid   (ax_valid),
        .angle       (ax_angle),
        .out_side    (ax_side_out)
    );

    ssm_cos u_cos_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ax_valid),
        .angle     (ax_angle),
        .in_side   (ax_side_out),
        .out_valid (cx_valid),
        .cos_mag   (cx_mag),
        .cos_neg   (cx_neg),
        .out_side  (cx_side)
    );

    // Second half: y moves by the flow at the updated, unwrapped x.
    ssm_angle u_angle_y (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (d2_valid_reg),
        .coord       (d2_xn_reg),
        .in_side     (d2_side_reg),
        .wave_number (wave_number_reg),
        .phase       (phase_y_reg),
        .out_valid   (ay_valid),
        .angle       (ay_angle),
        .out_side    (ay_side)
    );

    ssm_cos u_cos_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ay_valid),
        .angle     (ay_angle),
        .in_side   (ay_side),
        .out_valid (cy_valid),
        .cos_mag   (cy_mag),
        .cos_neg   (cy_neg),
        .out_side  (cy_side)
    );

    // Valid bits of the displacement stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_valid_reg <= 1'b0;
            d2_valid_reg <= 1'b0;
            d3_valid_reg <= 1'b0;
            d4_valid_reg <= 1'b0;
            inflight_reg <= 8'd0;
        end
        else
        begin
            d1_valid_reg <= cx_valid;
            d2_valid_reg <= d1_valid_reg;
            d3_valid_reg <= cy_valid;
            d4_valid_reg <= d3_valid_reg;
            inflight_reg <= inflight_next;
        end
    end

    // Displacement multiply, then the signed add.
    always_ff @(posedge clk)
    begin
        d1_d_reg    <= disp_mag(amp_mag, cx_mag);
        d1_neg_reg  <= amplitude_reg[31] ^ cx_neg;
        d1_side_reg <= cx_side;

        d2_xn_reg     <= add_disp(d1_side_reg.a, d1_d_reg, d1_neg_reg);
        d2_side_reg.a <= add_disp(d1_side_reg.a, d1_d_reg, d1_neg_reg);
        d2_side_reg.b <= d1_side_reg.b;

        d3_d_reg    <= disp_mag(amp_mag, cy_mag);
        d3_neg_reg  <= amplitude_reg[31] ^ cy_neg;
        d3_side_reg <= cy_side;

        d4_pair_reg.a <= d3_side_reg.a;
        d4_pair_reg.b <= add_disp(d3_side_reg.b, d3_d_reg, d3_neg_reg);
    end

    ssm_wrap u_wrap (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (d4_valid_reg),
        .coords        (d4_pair_reg),
        .domain_length (domain_length_reg),
        .out_valid     (done),
        .result        (result)
    );

    // Count of positions accepted whose results have not left yet.
    assign inflight_next = inflight_reg + 8'(start) - 8'(done);

    // A result beat needs an accepted position behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (inflight_reg != 8'd0))
        else $error("result beat with no position in flight");

    // Wrapped coordinates lie inside the domain.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (domain_length_reg != 32'd0)) |-> (result.new_x < domain_length_reg))
        else $error("new_x outside the domain");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (domain_length_reg != 32'd0)) |-> (result.new_y < domain_length_reg))
        else $error("new_y outside the domain");

endmodule
